@@ src/jac_pkg.sv @@
// Shared constants, register indexes and divider handshake types for the joystick
// axis conditioner. No dependencies; every other file refers to it by scoped names.
package jac_pkg;

    localparam int NUM_AXES = 4;
    localparam int SMP_W    = 12;
    localparam int AXIS_W   = 2;
    localparam int CAL_W    = 44;
    localparam int IDX_W    = 3;
    localparam int CAL_REGS = 4;
    localparam int DZ_W     = 7;

    // Register indexes on the configuration channel.
    localparam logic [IDX_W-1:0] REG_CAL0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_SLEW = 3'd4;

    localparam logic [CAL_W-1:0] CAL_RESET  = 44'd34376511488;
    localparam logic [SMP_W-1:0] SLEW_RESET = 12'd10;
    localparam logic [SMP_W-1:0] MID_CODE   = 12'd2048;
    localparam logic [10:0]      FULL_SCALE = 11'd2047;
    localparam logic [DZ_W-1:0]  DZ_MAX     = 7'd100;

    // The deadzone product (at most 100 * 4095) is divided by 200 as a shift by three
    // followed by a multiplication with the rounded-up reciprocal of 25.
    localparam int               DZ_PROD_W = 19;
    localparam int               DZ_PRE_SH = 3;
    localparam int               DZ_RCP_SH = 21;
    localparam int               DZ_RCP_PW = DZ_RCP_SH + SMP_W;
    localparam logic [16:0]      DZ_RECIP  = 17'd83887;

    localparam int               DIV_NUM_W = 24;
    localparam int               DIV_DEN_W = 12;
    localparam int               DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ src/jac_if.sv @@
// Valid/ready channel interfaces for the joystick axis conditioner: sample input,
// conditioned result output and register writes. Uses widths from jac_pkg.
interface jac_in_if;
    logic                       valid;
    logic                       ready;
    logic [jac_pkg::AXIS_W-1:0] axis;
    logic [jac_pkg::SMP_W-1:0]  sample;
    modport source (output valid, axis, sample, input ready);
    modport sink   (input valid, axis, sample, output ready);
endinterface

interface jac_out_if;
    logic                      valid;
    logic                      ready;
    logic [jac_pkg::SMP_W-1:0] position;
    logic [jac_pkg::SMP_W-1:0] slewed_sample;
    modport source (output valid, position, slewed_sample, input ready);
    modport sink   (input valid, position, slewed_sample, output ready);
endinterface

interface jac_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [jac_pkg::IDX_W-1:0] index;
    logic [jac_pkg::CAL_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/jac_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on jac_pkg for widths and the request/response structs.
module jac_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jac_pkg::t_div_req i_req,
    output jac_pkg::t_div_rsp o_rsp
);

    logic [jac_pkg::DIV_NUM_W-1:0] r_quo;
    logic [jac_pkg::DIV_DEN_W-1:0] r_rem;
    logic [jac_pkg::DIV_DEN_W-1:0] r_den;
    logic [jac_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [jac_pkg::DIV_DEN_W:0]   shifted;
    logic [jac_pkg::DIV_DEN_W:0]   diff;
    logic                          fits;

    always_comb begin
        shifted = {r_rem, r_quo[jac_pkg::DIV_NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= jac_pkg::DIV_CNT_W'(jac_pkg::DIV_NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == jac_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[jac_pkg::DIV_DEN_W-1:0] : shifted[jac_pkg::DIV_DEN_W-1:0];
            r_quo <= {r_quo[jac_pkg::DIV_NUM_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ src/joystick_axis_conditioner.sv @@
// Joystick axis conditioner: one request carries an axis number and a 12-bit sample and
// yields one result. The sample is slew-limited against the stored value of its axis, clamped
// to the axis range, passed through a centre deadzone and scaled to 1..4095 around 2048.
// The deadzone edges come from a reciprocal multiplication; the final scaling runs on a
// bit-serial divider, which is not started when the position is centre or full deflection.
// Input ready is high only while the sequencer is idle, so a request is taken only after the
// last one has finished; a finished result waits in an output register, so the next request
// can be taken while it is pending. Register writes are accepted at any time and must only
// happen while no request is in flight. Depends on jac_pkg, jac_if and jac_div.
module joystick_axis_conditioner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jac_in_if.sink      i_in,
    jac_out_if.source   o_out,
    jac_cfg_if.sink     i_cfg
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_CLAMP     = 9'b000000010,
        S_LO_DZ     = 9'b000000100,
        S_HI_MUL    = 9'b000001000,
        S_HI_DZ     = 9'b000010000,
        S_SIDE      = 9'b000100000,
        S_MAIN_GO   = 9'b001000000,
        S_MAIN_WAIT = 9'b010000000,
        S_FIN       = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [jac_pkg::CAL_W-1:0] r_cal [0:jac_pkg::CAL_REGS-1];
    logic [jac_pkg::SMP_W-1:0] r_slew;
    logic [jac_pkg::SMP_W-1:0] r_last_sample [0:jac_pkg::NUM_AXES-1];

    logic [jac_pkg::AXIS_W-1:0]    r_axis;
    logic                          r_bad;
    logic [jac_pkg::SMP_W-1:0]     r_last;
    logic [jac_pkg::SMP_W-1:0]     r_raw;
    logic [jac_pkg::DIV_NUM_W-1:0] r_prod;
    logic [jac_pkg::DIV_DEN_W-1:0] r_den;
    logic                          r_neg;
    logic signed [13:0]            r_dlo;
    logic signed [13:0]            r_dhi;
    logic signed [11:0]            r_res;

    logic                      r_out_valid;
    logic [jac_pkg::SMP_W-1:0] r_position;
    logic [jac_pkg::SMP_W-1:0] r_slewed;

    jac_pkg::t_div_req div_req;
    jac_pkg::t_div_rsp div_rsp;

    logic in_take;
    logic axis_ok;
    logic slew_up;
    logic slew_dn;
    logic [jac_pkg::SMP_W-1:0] slew_next;

    logic [jac_pkg::CAL_W-1:0] cal;
    logic [jac_pkg::SMP_W-1:0] cal_lo, cal_hi, cal_ctr;
    logic [jac_pkg::DZ_W-1:0]  dz;
    logic                      inv;
    logic signed [13:0]        s_lo, s_hi, s_ctr, s_raw;
    logic signed [13:0]        off, span_lo, span_hi, span, span_abs;
    logic signed [13:0]        lo_gap, hi_gap, den_lo, den_hi, gap_abs, s_dzq;
    logic                      lower;
    logic [jac_pkg::DIV_NUM_W-1:0] dz_prod;
    logic [jac_pkg::DZ_RCP_PW-1:0] dz_recip;
    logic [jac_pkg::SMP_W-1:0]     dz_quo;
    logic [jac_pkg::DIV_NUM_W-1:0] gap_prod;
    logic [10:0]               quo_sat;
    logic signed [11:0]        res_adj;
    logic [jac_pkg::SMP_W-1:0] clamped;

    assign in_take    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Slew limit: move by at most the step, otherwise land on the sample.
    always_comb begin
        axis_ok   = {1'b0, i_in.axis} < 3'(jac_pkg::NUM_AXES);
        slew_up   = {1'b0, i_in.sample} > ({1'b0, r_last_sample[i_in.axis]} + {1'b0, r_slew});
        slew_dn   = ({1'b0, i_in.sample} + {1'b0, r_slew}) < {1'b0, r_last_sample[i_in.axis]};
        if (slew_up) begin
            slew_next = r_last_sample[i_in.axis] + r_slew;
        end else if (slew_dn) begin
            slew_next = r_last_sample[i_in.axis] - r_slew;
        end else begin
            slew_next = i_in.sample;
        end
    end

    always_comb begin
        cal     = r_cal[r_axis];
        cal_lo  = cal[11:0];
        cal_hi  = cal[23:12];
        cal_ctr = cal[35:24];
        dz      = (cal[42:36] > jac_pkg::DZ_MAX) ? jac_pkg::DZ_MAX : cal[42:36];
        inv     = cal[43];

        // With the minimum above the maximum, a sample below the minimum is raised to it.
        if (r_last < cal_lo) begin
            clamped = cal_lo;
        end else if (r_last > cal_hi) begin
            clamped = cal_hi;
        end else begin
            clamped = r_last;
        end

        s_lo    = $signed({2'b00, cal_lo});
        s_hi    = $signed({2'b00, cal_hi});
        s_ctr   = $signed({2'b00, cal_ctr});
        s_raw   = $signed({2'b00, r_raw});
        off     = s_raw - s_ctr;
        span_lo = s_ctr - s_lo;
        span_hi = s_hi - s_ctr;

        span     = (r_state == S_CLAMP) ? span_lo : span_hi;
        span_abs = (span < 14'sd0) ? -span : span;
        dz_prod  = jac_pkg::DIV_NUM_W'(dz) * jac_pkg::DIV_NUM_W'(span_abs[11:0]);

        // Divide the registered deadzone product by 200.
        dz_recip = jac_pkg::DZ_RCP_PW'(r_prod[jac_pkg::DZ_PROD_W-1:jac_pkg::DZ_PRE_SH])
                   * jac_pkg::DZ_RCP_PW'(jac_pkg::DZ_RECIP);
        dz_quo   = dz_recip[jac_pkg::DZ_RCP_PW-1 -: jac_pkg::SMP_W];
        s_dzq    = $signed({2'b00, dz_quo});

        lo_gap  = off + r_dlo;
        hi_gap  = off - r_dhi;
        den_lo  = span_lo - r_dlo;
        den_hi  = span_hi - r_dhi;
        lower   = lo_gap < 14'sd0;
        gap_abs = lower ? -lo_gap : hi_gap;
        // Multiply by 2047 as a shift and subtract.
        gap_prod = {gap_abs[12:0], 11'b0} - jac_pkg::DIV_NUM_W'(gap_abs[12:0]);

        quo_sat = (div_rsp.quotient > jac_pkg::DIV_NUM_W'(jac_pkg::FULL_SCALE))
                  ? jac_pkg::FULL_SCALE : div_rsp.quotient[10:0];
        res_adj = inv ? -r_res : r_res;
    end

    always_comb begin
        div_req.start    = (r_state == S_MAIN_GO);
        div_req.dividend = r_prod;
        div_req.divisor  = r_den;
    end

    jac_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = axis_ok ? S_CLAMP : S_FIN;
                end
            end
            S_CLAMP:   n_state = S_LO_DZ;
            S_LO_DZ:   n_state = S_HI_MUL;
            S_HI_MUL:  n_state = lower ? S_SIDE : S_HI_DZ;
            S_HI_DZ:   n_state = S_SIDE;
            S_SIDE: begin
                if (lower) begin
                    n_state = (den_lo > 14'sd0) ? S_MAIN_GO : S_FIN;
                end else if (hi_gap > 14'sd0) begin
                    n_state = (den_hi > 14'sd0) ? S_MAIN_GO : S_FIN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MAIN_GO: n_state = S_MAIN_WAIT;
            S_MAIN_WAIT: begin
                if (div_rsp.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_slew      <= jac_pkg::SLEW_RESET;
            for (int i = 0; i < jac_pkg::CAL_REGS; i++) begin
                r_cal[i] <= jac_pkg::CAL_RESET;
            end
            for (int i = 0; i < jac_pkg::NUM_AXES; i++) begin
                r_last_sample[i] <= jac_pkg::MID_CODE;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index < jac_pkg::REG_SLEW) begin
                    r_cal[i_cfg.index[1:0]] <= i_cfg.data;
                end else if (i_cfg.index == jac_pkg::REG_SLEW) begin
                    r_slew <= i_cfg.data[jac_pkg::SMP_W-1:0];
                end
            end
            if (in_take && axis_ok) begin
                r_last_sample[i_in.axis] <= slew_next;
            end
            if (r_state == S_FIN && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_axis <= i_in.axis;
                    r_bad  <= !axis_ok;
                    r_last <= slew_next;
                end
            end
            S_CLAMP: begin
                r_raw  <= clamped;
                r_prod <= dz_prod;
                r_neg  <= span_lo < 14'sd0;
            end
            S_LO_DZ: begin
                r_dlo <= r_neg ? -s_dzq : s_dzq;
            end
            S_HI_MUL: begin
                r_prod <= dz_prod;
                r_neg  <= span_hi < 14'sd0;
            end
            S_HI_DZ: begin
                r_dhi <= r_neg ? -s_dzq : s_dzq;
            end
            S_SIDE: begin
                r_prod <= gap_prod;
                r_neg  <= lower;
                r_den  <= lower ? den_lo[11:0] : den_hi[11:0];
                // An empty or inverted side gives full deflection.
                if (lower) begin
                    r_res <= -$signed({1'b0, jac_pkg::FULL_SCALE});
                end else if (hi_gap > 14'sd0) begin
                    r_res <= $signed({1'b0, jac_pkg::FULL_SCALE});
                end else begin
                    r_res <= 12'sd0;
                end
            end
            S_MAIN_WAIT: begin
                if (div_rsp.done) begin
                    r_res <= r_neg ? -$signed({1'b0, quo_sat}) : $signed({1'b0, quo_sat});
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    r_position <= r_bad ? '0 : ($unsigned(res_adj) + jac_pkg::MID_CODE);
                    r_slewed   <= r_bad ? '0 : r_last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.position      = r_position;
    assign o_out.slewed_sample = r_slewed;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken again before the request finished");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_MAIN_WAIT))
        else $error("divider finished while nobody was waiting");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_res <= 12'sd2047 && r_res >= -12'sd2047))
        else $error("scaled position out of range");
`endif

endmodule
